>>> rtl/sorted_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted timer queue assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define STQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STQ_ASSERT_IMP(lbl, ante, cons, msg)
`define STQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// sorted timer queue package
// command codes, result kinds, slot flags and field widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stq_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 5;
  localparam int DL_W   = 32;
  localparam int PAY_W  = 8;
  localparam int Q_W    = 4;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 5;

  localparam logic [FUNC_W-1:0] F_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] F_FREE    = 3'd1;
  localparam logic [FUNC_W-1:0] F_INIT    = 3'd2;
  localparam logic [FUNC_W-1:0] F_SETTIME = 3'd3;
  localparam logic [FUNC_W-1:0] F_TICK    = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    K_ACK       = 3'd0,
    K_ALLOCATED = 3'd1,
    K_NONE_FREE = 3'd2,
    K_EXPIRED   = 3'd3,
    K_REJECTED  = 3'd4
  } kind_t;

  typedef logic [1:0] flag_t;
  localparam flag_t FLAG_FREE  = 2'd0;
  localparam flag_t FLAG_ALLOC = 2'd1;
  localparam flag_t FLAG_USING = 2'd2;

endpackage

>>> rtl/stq_in_if.sv
// ----------------------------------------------------------------------------
// sorted timer queue command channel
// valid/ready channel carrying one command transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stq_in_if import stq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   timer_id;
  logic [DL_W-1:0]   timeout;
  logic [PAY_W-1:0]  payload;
  logic [Q_W-1:0]    dest_queue;

  modport source (output valid, func, timer_id, timeout, payload, dest_queue, input ready);
  modport sink   (input valid, func, timer_id, timeout, payload, dest_queue, output ready);
endinterface

>>> rtl/stq_out_if.sv
// ----------------------------------------------------------------------------
// sorted timer queue result channel
// valid/ready channel carrying one result transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stq_out_if import stq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [PAY_W-1:0]  out_payload;
  logic [Q_W-1:0]    out_queue;
  logic              last;

  modport source (output valid, kind, slot, out_payload, out_queue, last, input ready);
  modport sink   (input valid, kind, slot, out_payload, out_queue, last, output ready);
endinterface

>>> rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// sorted timer queue ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted timer queue
//   channel  dir  handshake         contents
//   in_ch    in   valid/ready       func, timer_id, timeout, payload, dest_queue
//   out_ch   out  valid/ready       kind, slot, out_payload, out_queue, last
// one command at a time; the sorted id list sits in a single-port-read ram
// alloc scans the flags one slot a cycle, up to NUM_TIMERS slots
// settime: each entry searched: read id, read deadline, compare; each entry shifted: read, write
// tick: each entry checked: read id, read deadline, compare; then each remaining entry: read, write to compact
// synchronous active-low reset; a stalled result holds the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue import stq_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  logic clk,
  input  logic rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_SRCH_ID, S_SRCH_DL, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_TK_ID, S_TK_DL, S_TK_CMP, S_TK_FIN, S_CMP_RD, S_CMP_WR, S_RESP
  } state_t;

  state_t            st_r, st_nxt;
  logic [CW-1:0]     i_r, i_nxt, j_r, j_nxt, act_r, act_nxt;
  logic [DL_W-1:0]   tick_r, tick_nxt, dl_r, dl_nxt;
  logic [IW-1:0]     id_r, id_nxt, rslot_r, rslot_nxt, pslot_r, pslot_nxt;
  kind_t             kind_r, kind_nxt, okind_r, okind_nxt;
  logic              pend_r, pend_nxt;
  logic [PAY_W-1:0]  ppay_r, ppay_nxt, opay_r, opay_nxt;
  logic [Q_W-1:0]    pq_r, pq_nxt, oq_r, oq_nxt;
  logic              ov_r, ov_nxt, olast_r, olast_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  flag_t             flags_r [NUM_TIMERS];

  logic              flag_we;
  logic [IW-1:0]     flag_wa;
  flag_t             flag_wd;
  logic              ids_we, ids_re;
  logic [IW-1:0]     ids_wa, ids_wd, ids_ra, ids_rdata;
  logic              dl_we, dl_re;
  logic [IW-1:0]     dl_wa, dl_ra;
  logic [DL_W-1:0]   dl_wd, dl_rdata;
  logic              tg_we;
  logic [IW-1:0]     tg_wa;
  logic [PAY_W+Q_W-1:0] tg_wd, tg_rdata;

  logic              out_free, id_ok;
  logic [IW-1:0]     in_idx;
  logic [CW-1:0]     jm1, nj;

  stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(IW)) u_ids (
    .clk(clk), .we(ids_we), .waddr(ids_wa), .wdata(ids_wd),
    .re(ids_re), .raddr(ids_ra), .rdata(ids_rdata)
  );

  stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(DL_W)) u_dl (
    .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
    .re(dl_re), .raddr(dl_ra), .rdata(dl_rdata)
  );

  stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(PAY_W + Q_W)) u_tag (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd),
    .re(dl_re), .raddr(dl_ra), .rdata(tg_rdata)
  );

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.kind        = okind_r;
  assign out_ch.slot        = oslot_r;
  assign out_ch.out_payload = opay_r;
  assign out_ch.out_queue   = oq_r;
  assign out_ch.last        = olast_r;

  assign out_free = !ov_r || out_ch.ready;
  assign id_ok    = ({{(32-ID_W){1'b0}}, in_ch.timer_id} < 32'(NUM_TIMERS));
  assign in_idx   = IW'(in_ch.timer_id);
  assign jm1      = j_r - CW'(1);
  assign nj       = i_r + j_r;

  always_comb begin
    st_nxt    = st_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    act_nxt   = act_r;
    tick_nxt  = tick_r;
    dl_nxt    = dl_r;
    id_nxt    = id_r;
    rslot_nxt = rslot_r;
    pslot_nxt = pslot_r;
    kind_nxt  = kind_r;
    pend_nxt  = pend_r;
    ppay_nxt  = ppay_r;
    pq_nxt    = pq_r;
    ov_nxt    = ov_r && !out_ch.ready;
    okind_nxt = okind_r;
    oslot_nxt = oslot_r;
    opay_nxt  = opay_r;
    oq_nxt    = oq_r;
    olast_nxt = olast_r;
    flag_we   = 1'b0;
    flag_wa   = '0;
    flag_wd   = FLAG_FREE;
    ids_we    = 1'b0;
    ids_wa    = '0;
    ids_wd    = '0;
    ids_re    = 1'b0;
    ids_ra    = '0;
    dl_we     = 1'b0;
    dl_wa     = '0;
    dl_wd     = '0;
    dl_re     = 1'b0;
    dl_ra     = '0;
    tg_we     = 1'b0;
    tg_wa     = '0;
    tg_wd     = '0;

    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt    = in_idx;
          rslot_nxt = '0;
          kind_nxt  = K_ACK;
          i_nxt     = '0;
          st_nxt    = S_RESP;
          case (in_ch.func)
            F_ALLOC: begin
              st_nxt = S_ALLOC;
            end
            F_FREE: begin
              if (id_ok) begin
                flag_we = 1'b1;
                flag_wa = in_idx;
                flag_wd = FLAG_FREE;
              end else begin
                kind_nxt = K_REJECTED;
              end
            end
            F_INIT: begin
              if (id_ok) begin
                tg_we = 1'b1;
                tg_wa = in_idx;
                tg_wd = {in_ch.payload, in_ch.dest_queue};
              end else begin
                kind_nxt = K_REJECTED;
              end
            end
            F_SETTIME: begin
              if (!id_ok || flags_r[in_idx] == FLAG_USING ||
                  act_r == CW'(NUM_TIMERS)) begin
                kind_nxt = K_REJECTED;
              end else begin
                dl_nxt  = in_ch.timeout + tick_r;
                dl_we   = 1'b1;
                dl_wa   = in_idx;
                dl_wd   = in_ch.timeout + tick_r;
                flag_we = 1'b1;
                flag_wa = in_idx;
                flag_wd = FLAG_USING;
                st_nxt  = S_SRCH_ID;
              end
            end
            F_TICK: begin
              tick_nxt = tick_r + 32'd1;
              pend_nxt = 1'b0;
              st_nxt   = S_TK_ID;
            end
            default: begin
              kind_nxt = K_REJECTED;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (flags_r[i_r[IW-1:0]] == FLAG_FREE) begin
          flag_we   = 1'b1;
          flag_wa   = i_r[IW-1:0];
          flag_wd   = FLAG_ALLOC;
          kind_nxt  = K_ALLOCATED;
          rslot_nxt = i_r[IW-1:0];
          st_nxt    = S_RESP;
        end else if (i_r == CW'(NUM_TIMERS - 1)) begin
          kind_nxt = K_NONE_FREE;
          st_nxt   = S_RESP;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_SRCH_ID: begin
        if (i_r == act_r) begin
          j_nxt  = act_r;
          st_nxt = S_SHIFT_RD;
        end else begin
          ids_re = 1'b1;
          ids_ra = i_r[IW-1:0];
          st_nxt = S_SRCH_DL;
        end
      end
      S_SRCH_DL: begin
        dl_re  = 1'b1;
        dl_ra  = ids_rdata;
        st_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (dl_rdata >= dl_r) begin
          j_nxt  = act_r;
          st_nxt = S_SHIFT_RD;
        end else begin
          i_nxt  = i_r + CW'(1);
          st_nxt = S_SRCH_ID;
        end
      end
      S_SHIFT_RD: begin
        if (j_r > i_r) begin
          ids_re = 1'b1;
          ids_ra = jm1[IW-1:0];
          st_nxt = S_SHIFT_WR;
        end else begin
          ids_we  = 1'b1;
          ids_wa  = i_r[IW-1:0];
          ids_wd  = id_r;
          act_nxt = act_r + CW'(1);
          st_nxt  = S_RESP;
        end
      end
      S_SHIFT_WR: begin
        ids_we = 1'b1;
        ids_wa = j_r[IW-1:0];
        ids_wd = ids_rdata;
        j_nxt  = jm1;
        st_nxt = S_SHIFT_RD;
      end
      S_TK_ID: begin
        if (i_r == act_r) begin
          st_nxt = S_TK_FIN;
        end else begin
          ids_re = 1'b1;
          ids_ra = i_r[IW-1:0];
          st_nxt = S_TK_DL;
        end
      end
      S_TK_DL: begin
        dl_re  = 1'b1;
        dl_ra  = ids_rdata;
        st_nxt = S_TK_CMP;
      end
      S_TK_CMP: begin
        if (dl_rdata <= tick_r) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              ov_nxt    = 1'b1;
              okind_nxt = K_EXPIRED;
              oslot_nxt = SLOT_W'(pslot_r);
              opay_nxt  = ppay_r;
              oq_nxt    = pq_r;
              olast_nxt = 1'b0;
            end
            flag_we   = 1'b1;
            flag_wa   = ids_rdata;
            flag_wd   = FLAG_ALLOC;
            pend_nxt  = 1'b1;
            pslot_nxt = ids_rdata;
            ppay_nxt  = tg_rdata[PAY_W+Q_W-1:Q_W];
            pq_nxt    = tg_rdata[Q_W-1:0];
            i_nxt     = i_r + CW'(1);
            st_nxt    = S_TK_ID;
          end
        end else begin
          st_nxt = S_TK_FIN;
        end
      end
      S_TK_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          if (pend_r) begin
            okind_nxt = K_EXPIRED;
            oslot_nxt = SLOT_W'(pslot_r);
            opay_nxt  = ppay_r;
            oq_nxt    = pq_r;
          end else begin
            okind_nxt = K_ACK;
            oslot_nxt = '0;
            opay_nxt  = '0;
            oq_nxt    = '0;
          end
          act_nxt = act_r - i_r;
          j_nxt   = '0;
          st_nxt  = (i_r != '0) ? S_CMP_RD : S_IDLE;
        end
      end
      S_CMP_RD: begin
        if (j_r == act_r) begin
          st_nxt = S_IDLE;
        end else begin
          ids_re = 1'b1;
          ids_ra = nj[IW-1:0];
          st_nxt = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        ids_we = 1'b1;
        ids_wa = j_r[IW-1:0];
        ids_wd = ids_rdata;
        j_nxt  = j_r + CW'(1);
        st_nxt = S_CMP_RD;
      end
      S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          oslot_nxt = SLOT_W'(rslot_r);
          opay_nxt  = '0;
          oq_nxt    = '0;
          olast_nxt = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      act_r  <= '0;
      tick_r <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        flags_r[k] <= FLAG_FREE;
      end
    end else begin
      st_r   <= st_nxt;
      act_r  <= act_nxt;
      tick_r <= tick_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
      if (flag_we) begin
        flags_r[flag_wa] <= flag_wd;
      end
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    dl_r    <= dl_nxt;
    id_r    <= id_nxt;
    rslot_r <= rslot_nxt;
    pslot_r <= pslot_nxt;
    kind_r  <= kind_nxt;
    ppay_r  <= ppay_nxt;
    pq_r    <= pq_nxt;
    okind_r <= okind_nxt;
    oslot_r <= oslot_nxt;
    opay_r  <= opay_nxt;
    oq_r    <= oq_nxt;
    olast_r <= olast_nxt;
  end

  `STQ_ASSERT_IMP(a_act_bound, 1'b1, act_r <= CW'(NUM_TIMERS), "list length over capacity")
  `STQ_ASSERT_NXT(a_busy_after_cmd, in_ch.valid && in_ch.ready, !in_ch.ready, "command overlap")
  `STQ_ASSERT_IMP(a_walk_in_list, st_r == S_TK_CMP, i_r < act_r, "expiry walk past list end")

endmodule
